// File: rtl/core/assert_macros.svh
// Assertion macros for the checker file of the digit layout block.
// Expects signals named clock and reset in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define DDDL_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);
`define DDDL_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) \
      else $error(msg);
`endif

// File: rtl/core/dddl_pkg.sv
// Shared types, constants and helper functions of the decimal digit layout block.
// No dependencies; imported by the top level, dddl_bcd_conv and dddl_place.
package dddl_pkg;

   localparam int BIN_W      = 30;
   localparam int STEP_W     = $clog2(BIN_W);
   localparam int BCD_DIGITS = 9;
   localparam int CNT_W      = 5;
   localparam int PITCH_W    = 18;
   localparam int TOT_W      = 24;
   localparam int ANC_W      = 17;
   localparam int X_W        = 28;
   localparam int OUT_X_W    = 24;
   localparam int CSR_W      = 24;
   localparam int CSR_IDX_W  = 3;

   localparam logic signed [X_W-1:0] X_MAX = X_W'(8388607);
   localparam logic signed [X_W-1:0] X_MIN = -X_W'(8388608);

   typedef logic [BCD_DIGITS-1:0][3:0] bcd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAX_DIGITS     = 3'd0,
      CSR_MIN_DIGITS     = 3'd1,
      CSR_ALIGN_MODE     = 3'd2,
      CSR_ORIGIN_X       = 3'd3,
      CSR_DIGIT_WIDTH    = 3'd4,
      CSR_DIGIT_SPACING  = 3'd5,
      CSR_ANCHOR_FRACTION = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      ALIGN_LEFT   = 2'd0,
      ALIGN_CENTRE = 2'd1,
      ALIGN_RIGHT  = 2'd2
   } align_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_COUNT,
      ST_TOTAL,
      ST_PLACE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load_total;
      logic load_start;
      logic step;
   } place_ctl_type;

   function automatic logic [BIN_W-1:0] clamp_ceiling(input logic [3:0] md);
      logic [BIN_W-1:0] c;
      case (md) inside
         4'd0, 4'd1: c = BIN_W'(9);
         4'd2:       c = BIN_W'(99);
         4'd3:       c = BIN_W'(999);
         4'd4:       c = BIN_W'(9999);
         4'd5:       c = BIN_W'(99999);
         4'd6:       c = BIN_W'(999999);
         4'd7:       c = BIN_W'(9999999);
         4'd8:       c = BIN_W'(99999999);
         default:    c = BIN_W'(999999999);
      endcase
      return c;
   endfunction

   function automatic logic [OUT_X_W-1:0] sat_x(input logic signed [X_W-1:0] x);
      logic [OUT_X_W-1:0] r;
      if (x > X_MAX) begin
         r = X_MAX[OUT_X_W-1:0];
      end else if (x < X_MIN) begin
         r = X_MIN[OUT_X_W-1:0];
      end else begin
         r = x[OUT_X_W-1:0];
      end
      return r;
   endfunction

endpackage

// File: rtl/core/decimal_digit_display_layout.sv
// Channel   Ports                               Moves
// req       req_valid/req_ready                 one value per transfer
// rsp       rsp_valid/rsp_ready                 one digit slot per transfer
// csr       csr_write_enable/index/write_data   one register write, no wait
//
// An item passes through these steps, n being the shown digit count (1..16): the
// value is taken, converted in the serial BCD converter, laid out in the count,
// total and place states, and its n slots are then emitted one per transfer.
// Reset is synchronous; the registers return to their reset values and the shown count of the history clears to zero.
// A stalled rsp holds the sequencer; req is taken once the last slot is loaded.
// Top level of the digit layout block; uses dddl_pkg, dddl_bcd_conv, dddl_place.
module decimal_digit_display_layout import dddl_pkg::*; #(
   parameter int DIGIT_SLOTS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [31:0]        req_number_in,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [3:0]                rsp_slot_index,
   output logic [3:0]                rsp_digit_value,
   output logic                      rsp_digit_changed,
   output logic signed [OUT_X_W-1:0] rsp_x_position,
   output logic [CNT_W-1:0]          rsp_shown_count,
   output logic                      rsp_last_digit,
   input  logic                      csr_write_enable,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_W-1:0]          csr_write_data
);

   localparam int SHOWN_CAP = (DIGIT_SLOTS < 16) ? DIGIT_SLOTS : 16;
   localparam int SLOT_AW   = $clog2(DIGIT_SLOTS);

   logic [3:0]                max_digits_ff;
   logic [4:0]                min_digits_ff;
   logic [1:0]                align_mode_ff;
   logic signed [OUT_X_W-1:0] origin_x_ff;
   logic [15:0]               digit_width_ff;
   logic signed [15:0]        digit_spacing_ff;
   logic [8:0]                anchor_fraction_ff;

   state_type        state_ff, state_in;
   logic             conv_start, conv_done, load_count, load_out, is_last;
   logic             out_free;
   place_ctl_type    place_ctl;
   bcd_type          bcd;
   logic [BIN_W-1:0] ceiling, clamped;
   logic [CNT_W-1:0] len, mind, count_ff, count_in;
   logic [3:0]       slot_ff, slot_in, fr_ff, fr_in;
   logic [3:0]       digit_sel, prev_digit;
   logic             changed;
   logic [CNT_W-1:0] prev_count_ff, prev_count_in;
   logic [3:0]       prev_digit_ff [DIGIT_SLOTS];
   logic signed [X_W-1:0] x_cur;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [3:0]                rsp_slot_ff, rsp_digit_ff;
   logic                      rsp_changed_ff, rsp_last_ff;
   logic [OUT_X_W-1:0]        rsp_x_ff;
   logic [CNT_W-1:0]          rsp_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_digits_ff      <= 4'd9;
         min_digits_ff      <= 5'd1;
         align_mode_ff      <= ALIGN_LEFT;
         origin_x_ff        <= '0;
         digit_width_ff     <= '0;
         digit_spacing_ff   <= '0;
         anchor_fraction_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_MAX_DIGITS:      max_digits_ff      <= csr_write_data[3:0];
            CSR_MIN_DIGITS:      min_digits_ff      <= csr_write_data[4:0];
            CSR_ALIGN_MODE:      align_mode_ff      <= csr_write_data[1:0];
            CSR_ORIGIN_X:        origin_x_ff        <= csr_write_data;
            CSR_DIGIT_WIDTH:     digit_width_ff     <= csr_write_data[15:0];
            CSR_DIGIT_SPACING:   digit_spacing_ff   <= csr_write_data[15:0];
            CSR_ANCHOR_FRACTION: anchor_fraction_ff <= csr_write_data[8:0];
            default: ;
         endcase
      end
   end

   assign ceiling = clamp_ceiling(max_digits_ff);

   always_comb begin
      if (req_number_in[31]) begin
         clamped = '0;
      end else if (req_number_in[30:0] > {1'b0, ceiling}) begin
         clamped = ceiling;
      end else begin
         clamped = req_number_in[BIN_W-1:0];
      end
   end

   dddl_bcd_conv u_conv (
      .clock (clock),
      .reset (reset),
      .start (conv_start),
      .value (clamped),
      .done  (conv_done),
      .bcd   (bcd)
   );

   dddl_place u_place (
      .clock           (clock),
      .ctl             (place_ctl),
      .count           (count_ff),
      .origin_x        (origin_x_ff),
      .digit_width     (digit_width_ff),
      .digit_spacing   (digit_spacing_ff),
      .anchor_fraction (anchor_fraction_ff),
      .align_mode      (align_mode_ff),
      .x               (x_cur)
   );

   always_comb begin
      len = CNT_W'(1);
      for (int i = 0; i < BCD_DIGITS; i++) begin
         if (bcd[i] != 4'd0) begin
            len = CNT_W'(i + 1);
         end
      end
   end

   always_comb begin
      if (min_digits_ff == '0) begin
         mind = CNT_W'(1);
      end else if (min_digits_ff > CNT_W'(SHOWN_CAP)) begin
         mind = CNT_W'(SHOWN_CAP);
      end else begin
         mind = min_digits_ff;
      end
   end

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign is_last    = ({1'b0, slot_ff} + CNT_W'(1)) == count_ff;
   assign digit_sel  = (fr_ff < 4'(BCD_DIGITS)) ? bcd[fr_ff] : 4'd0;
   assign prev_digit = prev_digit_ff[SLOT_AW'(slot_ff)];
   assign changed    = ({1'b0, slot_ff} >= prev_count_ff) || (prev_digit != digit_sel);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:    if (req_valid) state_in = ST_CONVERT;
         ST_CONVERT: if (conv_done) state_in = ST_COUNT;
         ST_COUNT:   state_in = ST_TOTAL;
         ST_TOTAL:   state_in = ST_PLACE;
         ST_PLACE:   state_in = ST_EMIT;
         ST_EMIT:    if (out_free && is_last) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready            = (state_ff == ST_IDLE);
      conv_start           = req_ready && req_valid;
      load_count           = (state_ff == ST_COUNT);
      load_out             = (state_ff == ST_EMIT) && out_free;
      place_ctl.load_total = (state_ff == ST_TOTAL);
      place_ctl.load_start = (state_ff == ST_PLACE);
      place_ctl.step       = load_out;
   end

   always_comb begin
      count_in      = count_ff;
      slot_in       = slot_ff;
      fr_in         = fr_ff;
      prev_count_in = prev_count_ff;
      if (load_count) begin
         count_in = (len > mind) ? len : mind;
      end
      if (place_ctl.load_start) begin
         slot_in = '0;
         fr_in   = 4'(count_ff - CNT_W'(1));
      end else if (load_out) begin
         slot_in = slot_ff + 4'd1;
         fr_in   = fr_ff - 4'd1;
      end
      if (load_out && is_last) begin
         prev_count_in = count_ff;
      end
   end

   assign rsp_valid_in = load_out || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         prev_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         prev_count_ff <= prev_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
      slot_ff  <= slot_in;
      fr_ff    <= fr_in;
      if (load_out) begin
         rsp_slot_ff    <= slot_ff;
         rsp_digit_ff   <= digit_sel;
         rsp_changed_ff <= changed;
         rsp_x_ff       <= sat_x(x_cur);
         rsp_count_ff   <= count_ff;
         rsp_last_ff    <= is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         prev_digit_ff[SLOT_AW'(slot_ff)] <= digit_sel;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_slot_index    = rsp_slot_ff;
   assign rsp_digit_value   = rsp_digit_ff;
   assign rsp_digit_changed = rsp_changed_ff;
   assign rsp_x_position    = rsp_x_ff;
   assign rsp_shown_count   = rsp_count_ff;
   assign rsp_last_digit    = rsp_last_ff;

endmodule

// File: rtl/core/dddl_bcd_conv.sv
// Bit-serial binary to BCD converter (shift and add-3), one input bit per cycle.
// Depends on dddl_pkg.
module dddl_bcd_conv import dddl_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [BIN_W-1:0] value,
   output logic             done,
   output bcd_type          bcd
);

   logic [BIN_W-1:0]  bin_ff, bin_in;
   bcd_type           bcd_ff, bcd_in, adj;
   logic [4*BCD_DIGITS-1:0] adj_bits;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in;

   assign done     = busy_ff && (cnt_ff == STEP_W'(BIN_W - 1));
   assign bcd      = bcd_ff;
   assign adj_bits = adj;

   always_comb begin
      for (int i = 0; i < BCD_DIGITS; i++) begin
         adj[i] = (bcd_ff[i] >= 4'd5) ? bcd_ff[i] + 4'd3 : bcd_ff[i];
      end
   end

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         bin_in  = value;
         bcd_in  = '0;
      end else if (busy_ff) begin
         busy_in = !done;
         cnt_in  = cnt_ff + 1'b1;
         bin_in  = {bin_ff[BIN_W-2:0], 1'b0};
         bcd_in  = {adj_bits[4*BCD_DIGITS-2:0], bin_ff[BIN_W-1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

endmodule

// File: rtl/core/dddl_place.sv
// Layout arithmetic: row width, start position by alignment, anchor offset and
// per-slot stepping of the x position. Depends on dddl_pkg.
module dddl_place import dddl_pkg::*; (
   input  logic                      clock,
   input  place_ctl_type             ctl,
   input  logic [CNT_W-1:0]          count,
   input  logic signed [OUT_X_W-1:0] origin_x,
   input  logic [15:0]               digit_width,
   input  logic signed [15:0]        digit_spacing,
   input  logic [8:0]                anchor_fraction,
   input  logic [1:0]                align_mode,
   output logic signed [X_W-1:0]     x
);

   logic signed [PITCH_W-1:0] pitch;
   logic signed [TOT_W-1:0]   span;
   logic signed [TOT_W-1:0]   total_ff, total_in;
   logic [24:0]               anchor_prod;
   logic [ANC_W-1:0]          anchor_ff, anchor_in;
   logic signed [TOT_W-1:0]   shift_amt;
   logic signed [X_W-1:0]     x_ff, x_in;

   assign pitch       = $signed({2'b00, digit_width}) + PITCH_W'(digit_spacing);
   assign span        = $signed({1'b0, count}) * pitch;
   assign anchor_prod = digit_width * anchor_fraction;
   assign x           = x_ff;

   always_comb begin
      case (align_mode)
         ALIGN_CENTRE: shift_amt = total_ff >>> 1;
         ALIGN_RIGHT:  shift_amt = total_ff;
         default:      shift_amt = '0;
      endcase
   end

   always_comb begin
      total_in  = total_ff;
      anchor_in = anchor_ff;
      x_in      = x_ff;
      if (ctl.load_total) begin
         total_in  = span - TOT_W'(digit_spacing);
         anchor_in = anchor_prod[24:8];
      end
      if (ctl.load_start) begin
         x_in = X_W'(origin_x) - X_W'(shift_amt) + $signed(X_W'(anchor_ff));
      end else if (ctl.step) begin
         x_in = x_ff + X_W'(pitch);
      end
   end

   always_ff @(posedge clock) begin
      total_ff  <= total_in;
      anchor_ff <= anchor_in;
      x_ff      <= x_in;
   end

endmodule

// File: rtl/core/dddl_checker.sv
// Port-level checks of the digit layout block, bound to the top level.
// Depends on assert_macros.svh and on the top level's port names.
`include "assert_macros.svh"
module dddl_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [3:0]  rsp_slot_index,
   input logic [3:0]  rsp_digit_value,
   input logic [23:0] rsp_x_position,
   input logic [4:0]  rsp_shown_count,
   input logic        rsp_last_digit
);

   `DDDL_ASSERT_RST(a_rsp_clear_after_reset, reset |=> !rsp_valid, "rsp valid after reset")
   `DDDL_ASSERT(a_busy_after_req, req_valid && req_ready |=> !req_ready, "req taken while busy")
   `DDDL_ASSERT(a_last_matches_count, rsp_valid |-> rsp_last_digit == (({1'b0, rsp_slot_index} + 5'd1) == rsp_shown_count), "last flag off count")
   `DDDL_ASSERT(a_rsp_fields_range, rsp_valid |-> rsp_digit_value <= 4'd9 && rsp_shown_count != 5'd0 && rsp_shown_count <= 5'd16, "rsp field out of range")
   `DDDL_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_digit_value) && $stable(rsp_x_position) && $stable(rsp_slot_index), "stalled rsp changed")

endmodule

bind decimal_digit_display_layout dddl_checker u_checker (.*);

// File: verif/tb_top.sv
// Testbench for decimal_digit_display_layout: random and directed values under several
// register settings, with a built-in layout predictor and in-order slot checking.
// Depends on dddl_pkg and the RTL of the block only.
module tb_top import dddl_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 800000;
   localparam logic [1:0] ALIGN_UNUSED = 2'd3;

   typedef struct {
      logic [3:0]        slot;
      logic [3:0]        digit;
      logic              changed;
      logic signed [23:0] x;
      logic [4:0]        count;
      logic              last;
   } slot_result_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic signed [31:0]        req_number_in = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [3:0]                rsp_slot_index;
   logic [3:0]                rsp_digit_value;
   logic                      rsp_digit_changed;
   logic signed [OUT_X_W-1:0] rsp_x_position;
   logic [CNT_W-1:0]          rsp_shown_count;
   logic                      rsp_last_digit;
   logic                      csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]      csr_index = '0;
   logic [CSR_W-1:0]          csr_write_data = '0;

   // register copies, reset values
   logic [3:0]         cfg_max_digits = 4'd9;
   logic [4:0]         cfg_min_digits = 5'd1;
   logic [1:0]         cfg_align = ALIGN_LEFT;
   logic signed [23:0] cfg_origin = '0;
   logic [15:0]        cfg_width = '0;
   logic signed [15:0] cfg_spacing = '0;
   logic [8:0]         cfg_anchor = '0;

   logic [3:0]         shown_digits[16] = '{default: 4'd0};
   int                 shown_count_prev = 0;

   logic signed [31:0] numbers_to_send[$];
   slot_result_type    slots_due[$];
   logic signed [31:0] last_number = '0;

   int accepted_items = 0;
   int burst_left = 0;
   int gap_left = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   int ready_mode = 0;
   int mode_left = 0;
   int run_left = 0;
   int stall_step = 0;
   int errors = 0;
   int cycles = 0;

   decimal_digit_display_layout u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_number_in     (req_number_in),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_slot_index    (rsp_slot_index),
      .rsp_digit_value   (rsp_digit_value),
      .rsp_digit_changed (rsp_digit_changed),
      .rsp_x_position    (rsp_x_position),
      .rsp_shown_count   (rsp_shown_count),
      .rsp_last_digit    (rsp_last_digit),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report(input string msg);
      if (errors < 40) $display("mismatch: %s", msg);
      errors++;
   endtask

   // compute the shown slots of one value, queue them, and update the digit history
   task automatic layout_digits(input logic signed [31:0] number);
      longint          val, ceiling, w, sp, origin, total, start, anchor_off, x;
      int              md, mind, len, n;
      logic [3:0]      lsb[10];
      logic [3:0]      digits[16];
      slot_result_type r;
      md = (cfg_max_digits == 0) ? 1 : cfg_max_digits;
      if (md > 9) md = 9;
      ceiling = 1;
      repeat (md) ceiling *= 10;
      ceiling -= 1;
      val = number;
      if (val < 0) val = 0;
      else if (val > ceiling) val = ceiling;
      len = 0;
      do begin
         lsb[len] = 4'(val % 10);
         val = val / 10;
         len++;
      end while (val > 0);
      mind = (cfg_min_digits == 0) ? 1 : ((cfg_min_digits > 16) ? 16 : cfg_min_digits);
      n = (len > mind) ? len : mind;
      for (int i = 0; i < n; i++) begin
         digits[i] = (n - 1 - i < len) ? lsb[n - 1 - i] : 4'd0;
      end
      w = cfg_width;
      sp = cfg_spacing;
      origin = cfg_origin;
      total = n * w + (n - 1) * sp;
      case (cfg_align)
         ALIGN_CENTRE: start = origin - (total >>> 1);
         ALIGN_RIGHT:  start = origin - total;
         default:      start = origin;
      endcase
      anchor_off = (w * longint'(cfg_anchor)) >>> 8;
      for (int i = 0; i < n; i++) begin
         x = start + i * (w + sp) + anchor_off;
         if (x > 8388607) x = 8388607;
         if (x < -8388608) x = -8388608;
         r.slot = 4'(i);
         r.digit = digits[i];
         r.changed = (i >= shown_count_prev) || (shown_digits[i] != digits[i]);
         r.x = 24'(x);
         r.count = 5'(n);
         r.last = (i == n - 1);
         slots_due.insert(slots_due.size(), r);
      end
      for (int i = 0; i < n; i++) shown_digits[i] = digits[i];
      shown_count_prev = n;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            layout_digits(req_number_in);
            accepted_items <= accepted_items + 1;
         end
         if (!(req_valid && !req_ready)) begin
            if (gap_left != 0) begin
               gap_left <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (numbers_to_send.size() != 0) begin
               req_valid <= 1'b1;
               req_number_in <= numbers_to_send.pop_front();
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 12);
                  gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off, once, in the middle of the random traffic
   always @(posedge clock) begin
      if (!reset) begin
         if (!hold_done && accepted_items >= 220) begin
            hold_done <= 1'b1;
            hold_left <= 1500;
         end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            ready_mode <= $urandom_range(0, 3);
            mode_left <= $urandom_range(100, 600);
         end else begin
            mode_left <= mode_left - 1;
         end
         stall_step <= stall_step + 1;
         if (hold_left != 0) begin
            rsp_ready <= 1'b0;
         end else begin
            case (ready_mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'($urandom_range(0, 1));
               2: rsp_ready <= (stall_step % 3 == 0);
               default: begin
                  if (run_left == 0) begin
                     run_left <= $urandom_range(1, 16);
                     rsp_ready <= 1'($urandom_range(0, 1));
                  end else begin
                     run_left <= run_left - 1;
                  end
               end
            endcase
         end
      end
   end

   always @(posedge clock) begin : monitor
      slot_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (slots_due.size() == 0) begin
            report($sformatf("slot %0d with nothing expected", rsp_slot_index));
         end else begin
            want = slots_due.pop_front();
            if (rsp_slot_index !== want.slot)
               report($sformatf("slot_index %0d, want %0d", rsp_slot_index, want.slot));
            if (rsp_digit_value !== want.digit)
               report($sformatf("slot %0d digit %0d, want %0d", want.slot, rsp_digit_value,
                                want.digit));
            if (rsp_digit_changed !== want.changed)
               report($sformatf("slot %0d changed %0b, want %0b", want.slot, rsp_digit_changed,
                                want.changed));
            if (rsp_x_position !== want.x)
               report($sformatf("slot %0d x %0d, want %0d", want.slot, rsp_x_position, want.x));
            if (rsp_shown_count !== want.count)
               report($sformatf("slot %0d count %0d, want %0d", want.slot, rsp_shown_count,
                                want.count));
            if (rsp_last_digit !== want.last)
               report($sformatf("slot %0d last %0b, want %0b", want.slot, rsp_last_digit,
                                want.last));
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic write_reg(input csr_index_type idx, input logic [23:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      case (idx)
         CSR_MAX_DIGITS:      cfg_max_digits = data[3:0];
         CSR_MIN_DIGITS:      cfg_min_digits = data[4:0];
         CSR_ALIGN_MODE:      cfg_align = data[1:0];
         CSR_ORIGIN_X:        cfg_origin = data[23:0];
         CSR_DIGIT_WIDTH:     cfg_width = data[15:0];
         CSR_DIGIT_SPACING:   cfg_spacing = data[15:0];
         CSR_ANCHOR_FRACTION: cfg_anchor = data[8:0];
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      while (numbers_to_send.size() != 0 || req_valid || slots_due.size() != 0)
         @(negedge clock);
   endtask

   function automatic logic signed [31:0] pick_number(input logic signed [31:0] prev);
      longint p;
      int     k;
      case ($urandom_range(0, 7))
         0: return $urandom_range(0, 9);
         1: return $urandom_range(10, 9999);
         2: begin
            p = 1;
            k = $urandom_range(0, 9);
            repeat (k) p *= 10;
            return 32'(p - 1 + $urandom_range(0, 2));
         end
         3: return {1'b1, 31'($urandom)};
         4: return prev;
         5: return prev + $urandom_range(1, 9);
         6: return $urandom_range(32'd1000000000, 32'd2147483647);
         default: return $urandom;
      endcase
   endfunction

   task automatic run_phase(input logic [3:0] md, input logic [4:0] mind,
                            input logic [1:0] align, input logic [23:0] origin,
                            input logic [15:0] width, input logic [15:0] spacing,
                            input logic [8:0] anchor, input int count);
      write_reg(CSR_MAX_DIGITS, 24'(md));
      write_reg(CSR_MIN_DIGITS, 24'(mind));
      write_reg(CSR_ALIGN_MODE, 24'(align));
      write_reg(CSR_ORIGIN_X, origin);
      write_reg(CSR_DIGIT_WIDTH, 24'(width));
      write_reg(CSR_DIGIT_SPACING, 24'(spacing));
      write_reg(CSR_ANCHOR_FRACTION, 24'(anchor));
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
      repeat (count) begin
         last_number = pick_number(last_number);
         numbers_to_send.insert(numbers_to_send.size(), last_number);
      end
      wait_drained();
   endtask

   initial begin
      logic signed [31:0] directed[$];
      directed = '{0, 0, 7, 10, 99, 100, 999999999, 1000000000, 32'sh7FFFFFFF, -1,
                   32'sh80000000, 123456789, 123456780, 5, 5, 987654321, 1, 100000000,
                   32'sh55555555, 32'shAAAAAAAA, 4};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      foreach (directed[i]) numbers_to_send.insert(numbers_to_send.size(), directed[i]);
      wait_drained();

      run_phase(4'd15, 5'd31, ALIGN_UNUSED, 24'h7FFFFF, 16'hFFFF, 16'h7FFF, 9'd511, 40);
      run_phase(4'd0, 5'd0, ALIGN_RIGHT, 24'h800000, 16'hFFFF, 16'h8000, 9'd0, 40);
      run_phase(4'd9, 5'd3, ALIGN_CENTRE, 24'd100, 16'd3, -16'sd8, 9'd256, 50);
      run_phase(4'd9, 5'd4, ALIGN_CENTRE, 24'd2560, 16'd384, 16'd32, 9'd128, 50);
      repeat (5) begin
         run_phase(4'($urandom_range(0, 15)), 5'($urandom_range(0, 31)),
                   2'($urandom_range(0, 3)), 24'($urandom), 16'($urandom), 16'($urandom),
                   9'($urandom_range(0, 511)), 48);
      end

      repeat (60) @(posedge clock);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
